>>> rtl/itrp_pkg.sv
`default_nettype none
package itrp_pkg;

  // layer windows are powers of two, set by their address widths
  localparam int TEXT_AW = 11;
  localparam int BACK_AW = 13;
  localparam int FORE_AW = 12;

  localparam int TEXT_WORDS = 1 << TEXT_AW;
  localparam int BACK_WORDS = 1 << BACK_AW;
  localparam int FORE_WORDS = 1 << FORE_AW;

  // background pointer covers one bank
  localparam int BPTR_W = BACK_AW - 1;

  localparam int MAX_AW = (TEXT_AW > BACK_AW) ?
                          ((TEXT_AW > FORE_AW) ? TEXT_AW : FORE_AW) :
                          ((BACK_AW > FORE_AW) ? BACK_AW : FORE_AW);

  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_SET_PTR   = 2'd0;
  localparam logic [1:0] REQ_READ      = 2'd1;
  localparam logic [1:0] REQ_WRITE     = 2'd2;
  localparam logic [1:0] REQ_READ_TPTR = 2'd3;

  localparam logic [1:0] LAYER_TEXT = 2'd0;
  localparam logic [1:0] LAYER_BACK = 2'd1;
  localparam logic [1:0] LAYER_FORE = 2'd2;
  localparam logic [1:0] LAYER_NONE = 2'd3;

  localparam logic [1:0] LANE_WORD = 2'd0;
  localparam logic [1:0] LANE_LOW  = 2'd1;
  localparam logic [1:0] LANE_HIGH = 2'd2;
  localparam logic [1:0] LANE_NONE = 2'd3;

  typedef enum logic [1:0] {
    OP_IMM,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef enum logic {
    B_IDLE,
    B_DATA
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         layer;
    logic [1:0]         lane;
    logic [MAX_AW-1:0]  addr;
    logic [WORD_W-1:0]  data;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/itrp_req_if.sv
`default_nettype none
interface itrp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  layer;
  logic [1:0]  lane;
  logic [15:0] data;

  modport source (output valid, req_type, layer, lane, data, input ready);
  modport sink   (input valid, req_type, layer, lane, data, output ready);
endinterface
`default_nettype wire

>>> rtl/itrp_rsp_if.sv
`default_nettype none
interface itrp_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink   (input valid, read_value, output ready);
endinterface
`default_nettype wire

>>> rtl/itrp_cfg_if.sv
`default_nettype none
interface itrp_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/itrp_ram.sv
`default_nettype none
module itrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/itrp_queue.sv
`default_nettype none
module itrp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire itrp_pkg::entry_t push_entry,
  input  wire logic             pop,
  output itrp_pkg::entry_t      head,
  output logic                  full,
  output logic                  empty
);

  itrp_pkg::entry_t                  slots [itrp_pkg::QUEUE_DEPTH];
  logic [itrp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [itrp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [itrp_pkg::QCNT_W-1:0]       count;

  assign full  = (count == itrp_pkg::QCNT_W'(itrp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == itrp_pkg::QPTR_W'(itrp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == itrp_pkg::QPTR_W'(itrp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/itrp_front.sv
`default_nettype none
module itrp_front (
  input  wire logic         clk,
  input  wire logic         rst,
  itrp_req_if.sink          req,
  itrp_cfg_if.sink          cfg,
  input  wire logic         clearing,
  input  wire logic         q_full,
  output logic              push,
  output itrp_pkg::entry_t  push_entry
);

  logic [itrp_pkg::TEXT_AW-1:0] text_ptr;
  logic [itrp_pkg::BPTR_W-1:0]  back_ptr;
  logic [itrp_pkg::FORE_AW-1:0] fore_ptr;
  logic [itrp_pkg::WORD_W-1:0]  text_latch;
  logic [itrp_pkg::WORD_W-1:0]  back_latch;
  logic [itrp_pkg::WORD_W-1:0]  fore_latch;
  logic                         bg_bank;

  logic [itrp_pkg::WORD_W-1:0]  latch_cur;
  logic [itrp_pkg::WORD_W-1:0]  latch_next;
  logic [itrp_pkg::WORD_W-1:0]  ptr_src;
  logic                         set_ptr;

  assign req.ready = !clearing && !q_full;
  assign push      = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign set_ptr   = push && (req.req_type == itrp_pkg::REQ_SET_PTR) &&
                     (req.layer != itrp_pkg::LAYER_NONE);

  // byte assembly for pointer writes
  always_comb begin
    case (req.layer)
      itrp_pkg::LAYER_TEXT: latch_cur = text_latch;
      itrp_pkg::LAYER_BACK: latch_cur = back_latch;
      itrp_pkg::LAYER_FORE: latch_cur = fore_latch;
      default:              latch_cur = '0;
    endcase
    case (req.lane)
      itrp_pkg::LANE_LOW:  latch_next = {latch_cur[15:8], req.data[7:0]};
      itrp_pkg::LANE_HIGH: latch_next = {req.data[7:0], latch_cur[7:0]};
      default:             latch_next = latch_cur;
    endcase
    ptr_src = (req.lane == itrp_pkg::LANE_WORD) ? req.data : latch_next;
  end

  // classify into a queue entry, addresses resolved against current pointers
  always_comb begin
    push_entry       = '0;
    push_entry.op    = itrp_pkg::OP_IMM;
    push_entry.layer = req.layer;
    push_entry.lane  = req.lane;
    push_entry.data  = req.data;
    case (req.req_type)
      itrp_pkg::REQ_READ_TPTR: begin
        push_entry.data = itrp_pkg::WORD_W'(text_ptr);
      end
      itrp_pkg::REQ_SET_PTR: begin
        push_entry.data = '0;
      end
      default: begin
        if (req.layer == itrp_pkg::LAYER_NONE || req.lane == itrp_pkg::LANE_NONE) begin
          push_entry.data = '0;
        end else begin
          push_entry.op = (req.req_type == itrp_pkg::REQ_READ) ? itrp_pkg::OP_READ
                                                                : itrp_pkg::OP_WRITE;
          case (req.layer)
            itrp_pkg::LAYER_TEXT: push_entry.addr = itrp_pkg::MAX_AW'(text_ptr);
            itrp_pkg::LAYER_BACK: push_entry.addr = itrp_pkg::MAX_AW'({bg_bank, back_ptr});
            default:              push_entry.addr = itrp_pkg::MAX_AW'(fore_ptr);
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_ptr   <= '0;
      back_ptr   <= '0;
      fore_ptr   <= '0;
      text_latch <= '0;
      back_latch <= '0;
      fore_latch <= '0;
      bg_bank    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        bg_bank <= cfg.data;
      end
      if (set_ptr) begin
        case (req.layer)
          itrp_pkg::LAYER_TEXT: begin
            text_ptr <= ptr_src[itrp_pkg::TEXT_AW-1:0];
            if (req.lane != itrp_pkg::LANE_WORD) begin
              text_latch <= latch_next;
            end
          end
          itrp_pkg::LAYER_BACK: begin
            back_ptr <= ptr_src[itrp_pkg::BPTR_W-1:0];
            if (req.lane != itrp_pkg::LANE_WORD) begin
              back_latch <= latch_next;
            end
          end
          default: begin
            fore_ptr <= ptr_src[itrp_pkg::FORE_AW-1:0];
            if (req.lane != itrp_pkg::LANE_WORD) begin
              fore_latch <= latch_next;
            end
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/itrp_back.sv
`default_nettype none
module itrp_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire itrp_pkg::entry_t head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             clearing,
  itrp_rsp_if.source       rsp
);

  itrp_pkg::back_state_t          state;
  itrp_pkg::back_state_t          state_next;
  itrp_pkg::entry_t               cur;
  logic [itrp_pkg::MAX_AW-1:0]    clr_cnt;
  logic                           out_valid;
  logic [itrp_pkg::WORD_W-1:0]    out_value;

  logic [itrp_pkg::WORD_W-1:0]    text_rdata;
  logic [itrp_pkg::WORD_W-1:0]    back_rdata;
  logic [itrp_pkg::WORD_W-1:0]    fore_rdata;
  logic [itrp_pkg::WORD_W-1:0]    word;
  logic [itrp_pkg::WORD_W-1:0]    wword;
  logic [itrp_pkg::WORD_W-1:0]    result;
  logic                           done;
  logic                           do_write;
  logic                           text_we;
  logic                           back_we;
  logic                           fore_we;
  logic [itrp_pkg::MAX_AW-1:0]    waddr;
  logic [itrp_pkg::WORD_W-1:0]    wdata;

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done       = 1'b0;
    case (state)
      itrp_pkg::B_IDLE: begin
        if (!q_empty && !out_valid) begin
          pop        = 1'b1;
          state_next = itrp_pkg::B_DATA;
        end
      end
      itrp_pkg::B_DATA: begin
        done       = 1'b1;
        state_next = itrp_pkg::B_IDLE;
      end
      default: state_next = itrp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrp_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // word fetched for this op and its byte merge
  always_comb begin
    case (cur.layer)
      itrp_pkg::LAYER_TEXT: word = text_rdata;
      itrp_pkg::LAYER_BACK: word = back_rdata;
      default:              word = fore_rdata;
    endcase
    case (cur.lane)
      itrp_pkg::LANE_LOW:  wword = {word[15:8], cur.data[7:0]};
      itrp_pkg::LANE_HIGH: wword = {cur.data[7:0], word[7:0]};
      default:             wword = cur.data;
    endcase
    case (cur.op)
      itrp_pkg::OP_READ: begin
        case (cur.lane)
          itrp_pkg::LANE_LOW:  result = {8'h00, word[7:0]};
          itrp_pkg::LANE_HIGH: result = {8'h00, word[15:8]};
          default:             result = word;
        endcase
      end
      itrp_pkg::OP_WRITE: result = '0;
      default:            result = cur.data;
    endcase
  end

  assign do_write = done && (cur.op == itrp_pkg::OP_WRITE);
  assign text_we  = clearing || (do_write && cur.layer == itrp_pkg::LAYER_TEXT);
  assign back_we  = clearing || (do_write && cur.layer == itrp_pkg::LAYER_BACK);
  assign fore_we  = clearing || (do_write && cur.layer == itrp_pkg::LAYER_FORE);
  assign waddr    = clearing ? clr_cnt : cur.addr;
  assign wdata    = clearing ? '0 : wword;

  // zeroing sweep over all three memories after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_value <= result;
    end
  end

  itrp_ram #(
    .WIDTH (itrp_pkg::WORD_W),
    .DEPTH (itrp_pkg::TEXT_WORDS)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (waddr[itrp_pkg::TEXT_AW-1:0]),
    .wdata (wdata),
    .raddr (head.addr[itrp_pkg::TEXT_AW-1:0]),
    .rdata (text_rdata)
  );

  itrp_ram #(
    .WIDTH (itrp_pkg::WORD_W),
    .DEPTH (itrp_pkg::BACK_WORDS)
  ) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (waddr[itrp_pkg::BACK_AW-1:0]),
    .wdata (wdata),
    .raddr (head.addr[itrp_pkg::BACK_AW-1:0]),
    .rdata (back_rdata)
  );

  itrp_ram #(
    .WIDTH (itrp_pkg::WORD_W),
    .DEPTH (itrp_pkg::FORE_WORDS)
  ) u_fore_ram (
    .clk   (clk),
    .we    (fore_we),
    .waddr (waddr[itrp_pkg::FORE_AW-1:0]),
    .wdata (wdata),
    .raddr (head.addr[itrp_pkg::FORE_AW-1:0]),
    .rdata (fore_rdata)
  );

endmodule
`default_nettype wire

>>> rtl/indirect_tile_ram_port.sv
// indirect tile ram port: port-accessed video memory for text, background
// and foreground tile layers
// req channel: one request per handshake; set pointer, read data, write data
//   or read text pointer, with layer, byte lane and 16-bit data
// rsp channel: exactly one read_value per request, in request order; zero
//   for pointer sets and data writes
// cfg channel: one bit, bg_bank, picks the background bank for data accesses;
//   always ready, write it only while no request is in flight
// back end: a request accepted into an empty queue is popped straight into
//   the registered memory read, passes the write-back state and then the
//   response register; no new request is popped until the response register
//   has emptied, so the back end finishes one request before taking the next
// pointer state is updated by the front end at accept, so later requests see
//   it at once; the two-entry queue lets the front keep taking requests
//   while the back end or the response register waits
// reset: pointers, latches and bg_bank clear at once; then a sweep zeroes all
//   three memories over the largest layer depth, 8192 words, with req.ready low
// receiver stall: the response register holds until rsp.ready; the back end
//   stops popping, the queue fills and req.ready drops
`default_nettype none
module indirect_tile_ram_port (
  input  wire logic  clk,
  input  wire logic  rst,
  itrp_req_if.sink   req,
  itrp_rsp_if.source rsp,
  itrp_cfg_if.sink   cfg
);

  // front to queue
  logic             push;
  itrp_pkg::entry_t push_entry;
  // queue to back
  itrp_pkg::entry_t head;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  // back reports memory sweep in progress
  logic             clearing;

  itrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .clearing   (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  itrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  itrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire

>>> rtl/itrp_checker.sv
`default_nettype none
module itrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] rsp_read_value
);

  // no response survives reset
  a_rst_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // memory sweep keeps requests out right after reset
  a_rst_ready: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready during memory sweep");

  // stalled response holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
    else $error("stalled response changed");

endmodule

bind indirect_tile_ram_port itrp_checker u_itrp_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value)
);
`default_nettype wire
